// File: design/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Types, constants and helper functions shared by the scrambled Sobol
// sample generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

  localparam logic [63:0] GOLDEN64 = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX64_C1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX64_C2 = 64'h94D0_49BB_1331_11EB;
  localparam logic [31:0] MIX32_C1 = 32'h7FEB_352D;
  localparam logic [31:0] MIX32_C2 = 32'h846C_A68B;
  localparam logic [63:0] DIM_MUL  = 64'hD1B5_4A32_D192_ED03;
  localparam logic [31:0] OWEN_C0  = 32'h6C50_B47C;
  localparam logic [31:0] OWEN_C1  = 32'hB82F_1E52;
  localparam logic [31:0] OWEN_C2  = 32'hC7AF_E638;
  localparam logic [31:0] OWEN_C3  = 32'h8D22_F6E6;
  localparam logic [23:0] HALF_24  = 24'h80_0000;

  localparam logic [1:0] MODE_INDEP  = 2'd0;
  localparam logic [1:0] MODE_OWEN   = 2'd1;
  localparam logic [1:0] MODE_ZSOBOL = 2'd2;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_SEED      = 2'd1;
  localparam logic [1:0] REG_SPP       = 2'd2;
  localparam logic [1:0] REG_PIX_DIM   = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] sample_number;
    logic [9:0]  dimension;
    logic [15:0] lane;
  } in_item_t;

  typedef struct packed {
    logic [23:0] first_value;
    logic [23:0] second_value;
  } out_item_t;

  typedef struct packed {
    logic        two;
    logic        centre;
    logic        owen;
    logic        zsobol;
    logic [15:0] sn;
    logic [31:0] idx;
    logic [31:0] ax1_rev;
  } side_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] cr;
  } mul_part_t;

  function automatic mul_part_t mul_part(input logic [63:0] a, input logic [63:0] c);
    mul_part_t   p;
    logic [31:0] m1;
    logic [31:0] m2;
    p.ll = {32'b0, a[31:0]} * {32'b0, c[31:0]};
    m1   = a[31:0] * c[63:32];
    m2   = a[63:32] * c[31:0];
    p.cr = m1 + m2;
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input mul_part_t p);
    return p.ll + {p.cr, 32'b0};
  endfunction

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  function automatic logic [31:0] spread16(input logic [15:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [31:0] sobol_axis1(input logic [31:0] idx);
    logic [31:0] dir;
    logic [31:0] acc;
    dir = 32'h8000_0000;
    acc = '0;
    for (int i = 0; i < 32; i++) begin
      if (idx[i]) begin
        acc = acc ^ dir;
      end
      dir = dir ^ (dir >> 1);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: design/scrambled_sobol_sample_generator_unit.sv
// ----------------------------------------------------------------------------
// scrambled_sobol_sample_generator_unit
// Stateless 2-D Owen-scrambled Sobol / Z-Sobol / hash sample generator.
//
// Requests arrive on in_valid/in_ready/in_data; each gives exactly one
// result on out_valid/out_ready/out_data, in request order. Registers must
// be written through cfg_we/cfg_index/cfg_data only while the unit is idle;
// the unit itself does not enforce this. The datapath is an 18-stage
// pipeline that sustains one transfer per cycle unless the receiver stalls.
// The depth is set by the mix64 chains (each 64-bit multiply split over
// two stages) followed by mix32 and the four-multiply scramble.
// When the receiver stalls the whole pipeline holds and in_ready drops
// until the output register is taken. Reset empties the pipeline and
// loads mode 1, seed 0, one sample per pixel and pixel dimension 0.
// ----------------------------------------------------------------------------
`default_nettype none

module scrambled_sobol_sample_generator_unit
  import sss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [1:0]  mode;
  logic [63:0] scene_key;
  logic [16:0] spp_count;
  logic [9:0]  pixel_dimension_id;

  logic [18:1] vld;
  logic        en;
  side_t       side [1:17];

  logic [63:0] a1;
  mul_part_t   dp1 [2];
  mul_part_t   lp1;
  mul_part_t   pa2;
  logic [63:0] ds2 [2];
  logic [63:0] ls2;
  logic [63:0] b3;
  logic [63:0] t3 [2];
  mul_part_t   pb4;
  logic [63:0] t4 [2];
  logic [63:0] c5;
  logic [63:0] t5 [2];
  logic [63:0] h6 [2];
  mul_part_t   p7 [2];
  logic [63:0] q8 [2];
  mul_part_t   p9 [2];
  logic [63:0] r10 [2];
  logic [31:0] y11 [2];
  logic [31:0] z12 [2];
  logic [31:0] u13 [2];
  logic [31:0] w13 [2];
  logic [31:0] w14 [2];
  logic [31:0] w15 [2];
  logic [31:0] w16 [2];
  logic [31:0] w17 [2];
  logic [31:0] ow17 [2];

  side_t       s1_next;
  logic [4:0]  sbits;
  logic [31:0] morton;
  logic [31:0] idx;
  logic [63:0] pseed;
  logic [63:0] s64;
  logic [63:0] hx6 [2];
  logic [63:0] mx11 [2];
  logic [31:0] f11 [2];
  logic [31:0] g12 [2];
  logic [31:0] w13_next [2];
  logic [31:0] word [2];
  out_item_t   res;

  assign en       = !vld[18] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[18];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_OWEN;
      scene_key          <= '0;
      spp_count          <= 17'd1;
      pixel_dimension_id <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    mode               <= cfg_data[1:0];
        REG_SEED:    scene_key          <= cfg_data;
        REG_SPP:     spp_count          <= cfg_data[16:0];
        REG_PIX_DIM: pixel_dimension_id <= cfg_data[9:0];
        default:     mode               <= mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[17:1], in_valid};
    end
  end

  always_comb begin
    sbits = '0;
    for (int i = 0; i < 17; i++) begin
      if (spp_count > (17'd1 << i)) begin
        sbits = 5'(i + 1);
      end
    end
    morton = spread16(in_data.pixel_x) | (spread16(in_data.pixel_y) << 1);
    if (mode == MODE_ZSOBOL) begin
      idx = (morton << sbits) | {16'b0, in_data.sample_number};
    end else begin
      idx = {16'b0, in_data.sample_number};
    end
    s1_next.two     = in_data.kind;
    s1_next.centre  = in_data.kind && (in_data.dimension == pixel_dimension_id) &&
                      (spp_count <= 17'd1);
    s1_next.owen    = (mode == MODE_OWEN) || (mode == MODE_ZSOBOL);
    s1_next.zsobol  = (mode == MODE_ZSOBOL);
    s1_next.sn      = in_data.sample_number;
    s1_next.idx     = idx;
    s1_next.ax1_rev = rev32(sobol_axis1(idx));
  end

  always_comb begin
    pseed = c5 ^ (c5 >> 31);
    if (side[5].zsobol) begin
      s64 = scene_key;
    end else if (side[5].owen) begin
      s64 = side[5].two ? pseed : (pseed ^ GOLDEN64);
    end else begin
      s64 = pseed ^ {48'b0, side[5].sn};
    end
    for (int k = 0; k < 2; k++) begin
      hx6[k]  = s64 ^ t5[k];
      mx11[k] = r10[k] ^ (r10[k] >> 31);
      f11[k]  = mx11[k][31:0] ^ mx11[k][63:32];
      f11[k]  = f11[k] ^ (f11[k] >> 16);
      g12[k]  = y11[k] ^ (y11[k] >> 15);
      w13_next[k] = z12[k] ^ (z12[k] >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= s1_next;
      for (int s = 2; s <= 17; s++) begin
        side[s] <= side[s-1];
      end

      a1     <= (scene_key ^ {16'b0, in_data.pixel_x, 32'b0} ^
                 {48'b0, in_data.pixel_y}) + GOLDEN64;
      dp1[0] <= mul_part({54'b0, in_data.dimension}, DIM_MUL);
      dp1[1] <= mul_part({53'b0, {1'b0, in_data.dimension} + 11'd1}, DIM_MUL);
      lp1    <= mul_part({48'b0, in_data.lane}, MIX64_C2);

      pa2    <= mul_part(a1 ^ (a1 >> 30), MIX64_C1);
      ls2    <= mul_sum(lp1);
      b3     <= mul_sum(pa2);
      pb4    <= mul_part(b3 ^ (b3 >> 27), MIX64_C2);
      c5     <= mul_sum(pb4);

      for (int k = 0; k < 2; k++) begin
        ds2[k]  <= mul_sum(dp1[k]);
        t3[k]   <= ds2[k] ^ ls2;
        t4[k]   <= t3[k];
        t5[k]   <= t4[k];
        h6[k]   <= hx6[k] + GOLDEN64;
        p7[k]   <= mul_part(h6[k] ^ (h6[k] >> 30), MIX64_C1);
        q8[k]   <= mul_sum(p7[k]);
        p9[k]   <= mul_part(q8[k] ^ (q8[k] >> 27), MIX64_C2);
        r10[k]  <= mul_sum(p9[k]);
        y11[k]  <= f11[k] * MIX32_C1;
        z12[k]  <= g12[k] * MIX32_C2;
        w13[k]  <= w13_next[k];
        w14[k]  <= w13[k];
        w15[k]  <= w14[k];
        w16[k]  <= w15[k];
        w17[k]  <= w16[k];
      end
      u13[0] <= side[12].idx + w13_next[0];
      u13[1] <= side[12].ax1_rev + w13_next[1];
    end
  end

  sss_owen u_owen0 (
    .clk   (clk),
    .en    (en),
    .u_in  (u13[0]),
    .u_out (ow17[0])
  );

  sss_owen u_owen1 (
    .clk   (clk),
    .en    (en),
    .u_in  (u13[1]),
    .u_out (ow17[1])
  );

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      word[k] = side[17].owen ? rev32(ow17[k]) : w17[k];
    end
    if (side[17].centre) begin
      res.first_value  = HALF_24;
      res.second_value = HALF_24;
    end else begin
      res.first_value  = word[0][31:8];
      res.second_value = side[17].two ? word[1][31:8] : 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// File: design/sss_owen.sv
// ----------------------------------------------------------------------------
// sss_owen
// Four-stage Laine-Karras scramble chain on a 32-bit word, one multiply
// per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_owen
  import sss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] u_in,
  output logic [31:0]      u_out
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;
  logic [31:0] t4;
  logic [31:0] m0;
  logic [31:0] m1;
  logic [31:0] m2;
  logic [31:0] m3;

  always_comb begin
    m0 = u_in * OWEN_C0;
    m1 = t1 * OWEN_C1;
    m2 = t2 * OWEN_C2;
    m3 = t3 * OWEN_C3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= u_in ^ m0;
      t2 <= t1 ^ m1;
      t3 <= t2 ^ m2;
      t4 <= t3 ^ m3;
    end
  end

  assign u_out = t4;

endmodule

`default_nettype wire
